### sv/htc_pkg.sv
package htc_pkg;

  localparam int unsigned COEF_BITS         = 16;
  localparam int unsigned FRACTION_BITS_DEF = 8;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 64;

  localparam logic [CFG_IDX_W-1:0] REG_CALIB_LO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_HI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USER_REF_L = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USER_MEA_L = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_USER_REF_H = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_USER_MEA_H = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFS   = 3'd6;

  typedef struct packed {
    logic signed [31:0] t_slope;
    logic signed [31:0] t_icpt;
    logic signed [31:0] h_slope;
    logic signed [31:0] h_icpt;
    logic signed [31:0] u_slope;
    logic signed [31:0] u_icpt;
  } coef_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_SLOPE,
    ST_PRODUCT,
    ST_STORE
  } coef_state_e;

  typedef enum logic [1:0] {
    JOB_TEMP,
    JOB_HUM,
    JOB_USER
  } job_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### sv/htc_coef.sv
module htc_coef #(
  parameter int unsigned FRACTION_BITS = htc_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                recalc_i,
  input  logic [127:0]        calib_i,
  input  logic signed [15:0]  ref_low_i,
  input  logic signed [15:0]  mea_low_i,
  input  logic signed [15:0]  ref_high_i,
  input  logic signed [15:0]  mea_high_i,
  output htc_pkg::coef_t      coef_o,
  output logic                busy_o
);
  import htc_pkg::*;

  localparam int unsigned NUM_W  = 48;
  localparam int unsigned DEN_W  = 17;
  localparam int unsigned CNT_W  = $clog2(NUM_W);
  localparam int unsigned T_SH   = FRACTION_BITS - 3 + COEF_BITS;
  localparam int unsigned H_SH   = FRACTION_BITS - 1 + COEF_BITS;
  localparam int unsigned U_SH   = COEF_BITS;
  localparam int unsigned T_BSH  = FRACTION_BITS - 3;
  localparam int unsigned H_BSH  = FRACTION_BITS - 1;
  localparam logic signed [31:0] ONE = 32'sd1 <<< COEF_BITS;
  localparam logic signed [47:0] HALF = 48'sd1 <<< (COEF_BITS - 1);

  coef_state_e state_q, state_d;
  job_e        job_q, job_d;
  logic        pending_q;
  logic [CNT_W-1:0] cnt_q;

  logic ld_setup, div_step, ld_slope, ld_prod, ld_store, go;

  logic [NUM_W-1:0]   div_q;
  logic [DEN_W:0]     rem_q;
  logic [DEN_W-1:0]   ad_q;
  logic               neg_q, degen_q;
  logic signed [15:0] out0_q;
  logic signed [31:0] base_q;
  logic signed [31:0] slope_q;
  logic signed [47:0] prod_q;
  coef_t              coef_q;

  logic signed [16:0] v0, v1;
  logic signed [15:0] out0, out1;
  logic signed [31:0] base;
  logic [5:0]         sh;
  logic signed [17:0] dv;
  logic signed [16:0] den;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]   an;
  logic [DEN_W-1:0]   ad;

  logic [DEN_W:0]     rem_sh;
  logic               qbit;
  logic signed [NUM_W:0] qv;
  logic signed [31:0] rnd;
  logic signed [33:0] icpt_sum;
  logic signed [31:0] icpt;

  always_comb begin
    v0   = '0;
    v1   = '0;
    out0 = '0;
    out1 = '0;
    base = '0;
    sh   = 6'(U_SH);
    case (job_q)
      JOB_TEMP: begin
        v0   = 17'({calib_i[41:40], calib_i[23:16]});
        v1   = 17'({calib_i[43:42], calib_i[31:24]});
        out0 = calib_i[111:96];
        out1 = calib_i[127:112];
        base = 32'(v0) <<< T_BSH;
        sh   = 6'(T_SH);
      end
      JOB_HUM: begin
        v0   = 17'(calib_i[7:0]);
        v1   = 17'(calib_i[15:8]);
        out0 = calib_i[63:48];
        out1 = calib_i[95:80];
        base = 32'(v0) <<< H_BSH;
        sh   = 6'(H_SH);
      end
      default: begin
        v0   = 17'(ref_low_i);
        v1   = 17'(ref_high_i);
        out0 = mea_low_i;
        out1 = mea_high_i;
        base = 32'(ref_low_i);
        sh   = 6'(U_SH);
      end
    endcase
    dv  = 18'(v1) - 18'(v0);
    den = 17'(out1) - 17'(out0);
    num = NUM_W'(dv) <<< sh;
    ad  = (den < 0) ? DEN_W'(-den) : DEN_W'(den);
    an  = ((num < 0) ? NUM_W'(-num) : NUM_W'(num)) + NUM_W'(ad >> 1);
  end

  always_comb begin
    rem_sh   = {rem_q[DEN_W-1:0], div_q[NUM_W-1]};
    qbit     = rem_sh >= {1'b0, ad_q};
    qv       = neg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    rnd      = 32'((prod_q + HALF) >>> COEF_BITS);
    icpt_sum = 34'(base_q) - 34'(rnd);
    icpt     = sat32(64'(icpt_sum));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (pending_q) state_d = ST_SETUP;
      ST_SETUP:   state_d = (out1 == out0) ? ST_STORE : ST_DIVIDE;
      ST_DIVIDE:  if (cnt_q == CNT_W'(NUM_W - 1)) state_d = ST_SLOPE;
      ST_SLOPE:   state_d = ST_PRODUCT;
      ST_PRODUCT: state_d = ST_STORE;
      ST_STORE:   state_d = (job_q == JOB_USER) ? ST_IDLE : ST_SETUP;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    go       = 1'b0;
    ld_setup = 1'b0;
    div_step = 1'b0;
    ld_slope = 1'b0;
    ld_prod  = 1'b0;
    ld_store = 1'b0;
    job_d    = job_q;
    case (state_q)
      ST_IDLE: begin
        go    = pending_q;
        job_d = JOB_TEMP;
      end
      ST_SETUP:   ld_setup = 1'b1;
      ST_DIVIDE:  div_step = 1'b1;
      ST_SLOPE:   ld_slope = 1'b1;
      ST_PRODUCT: ld_prod  = 1'b1;
      ST_STORE: begin
        ld_store = 1'b1;
        case (job_q)
          JOB_TEMP: job_d = JOB_HUM;
          JOB_HUM:  job_d = JOB_USER;
          default:  job_d = JOB_TEMP;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      job_q     <= JOB_TEMP;
      pending_q <= 1'b0;
      cnt_q     <= '0;
      coef_q    <= '{t_slope: '0, t_icpt: '0, h_slope: '0, h_icpt: '0,
                     u_slope: ONE, u_icpt: '0};
    end else begin
      state_q   <= state_d;
      job_q     <= job_d;
      pending_q <= recalc_i | (pending_q & ~go);
      cnt_q     <= div_step ? cnt_q + 1'b1 : '0;
      if (ld_store) begin
        case (job_q)
          JOB_TEMP: begin
            coef_q.t_slope <= slope_q;
            coef_q.t_icpt  <= degen_q ? '0 : icpt;
          end
          JOB_HUM: begin
            coef_q.h_slope <= slope_q;
            coef_q.h_icpt  <= degen_q ? '0 : icpt;
          end
          default: begin
            coef_q.u_slope <= slope_q;
            coef_q.u_icpt  <= degen_q ? '0 : icpt;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_setup) begin
      div_q   <= an;
      rem_q   <= '0;
      ad_q    <= ad;
      neg_q   <= (num < 0) != (den < 0);
      degen_q <= out1 == out0;
      out0_q  <= out0;
      base_q  <= base;
      slope_q <= (job_q == JOB_USER) ? ONE : '0;
    end
    if (div_step) begin
      rem_q <= qbit ? rem_sh - {1'b0, ad_q} : rem_sh;
      div_q <= {div_q[NUM_W-2:0], qbit};
    end
    if (ld_slope) begin
      slope_q <= sat32(64'(qv));
    end
    if (ld_prod) begin
      prod_q <= 48'(slope_q) * 48'(out0_q);
    end
  end

  assign coef_o = coef_q;
  assign busy_o = pending_q | (state_q != ST_IDLE);

endmodule

### sv/humidity_temperature_calibrate.sv
// Accepted samples pass the product, fit, user-product and output registers.
// Throughput: one sample word per cycle while coefficients are settled.
// A write to a calibration or user point register raises busy while the
// shared serial divider refits all three lines. Reset clears the config,
// coefficient and valid registers; coefficients start at zero factory lines
// and an identity user correction. The receiver cannot stall.
module humidity_temperature_calibrate #(
  parameter int unsigned FRACTION_BITS = htc_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [15:0]               humidity_sample_i,
  input  logic signed [15:0]               temperature_sample_i,
  input  logic                             cfg_we_i,
  input  logic [htc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [htc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic signed [15:0]               temperature_value_o,
  output logic [14:0]                      humidity_value_o,
  output logic                             temperature_saturated_o,
  output logic                             result_valid_o
);
  import htc_pkg::*;

  localparam int unsigned HMAX_RAW = 100 << FRACTION_BITS;
  localparam int unsigned HMAX     = (HMAX_RAW > 32767) ? 32767 : HMAX_RAW;
  localparam logic signed [47:0] HALF48 = 48'sd1 <<< (COEF_BITS - 1);
  localparam logic signed [63:0] HALF64 = 64'sd1 <<< (COEF_BITS - 1);

  logic [63:0]        calib_lo_q, calib_hi_q;
  logic signed [15:0] ref_l_q, mea_l_q, ref_h_q, mea_h_q, ofs_q;
  logic               recalc;
  coef_t              coef;
  logic               coef_busy;

  logic [3:0]         vld_q;
  logic signed [47:0] pt_q, ph_q;
  logic signed [31:0] fac_q;
  logic [14:0]        h2_q, h3_q;
  logic signed [63:0] pu_q;

  logic signed [33:0] fac_sum, h_sum;
  logic signed [31:0] fac_d;
  logic [14:0]        h2_d;
  logic signed [49:0] t_sum;
  logic signed [15:0] t_d;
  logic               sat_d;

  assign recalc = cfg_we_i && (cfg_index_i == REG_CALIB_LO || cfg_index_i == REG_CALIB_HI ||
                  cfg_index_i == REG_USER_REF_L || cfg_index_i == REG_USER_MEA_L ||
                  cfg_index_i == REG_USER_REF_H || cfg_index_i == REG_USER_MEA_H);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_lo_q <= '0;
      calib_hi_q <= '0;
      ref_l_q    <= '0;
      mea_l_q    <= '0;
      ref_h_q    <= '0;
      mea_h_q    <= '0;
      ofs_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CALIB_LO:   calib_lo_q <= cfg_data_i;
        REG_CALIB_HI:   calib_hi_q <= cfg_data_i;
        REG_USER_REF_L: ref_l_q    <= cfg_data_i[15:0];
        REG_USER_MEA_L: mea_l_q    <= cfg_data_i[15:0];
        REG_USER_REF_H: ref_h_q    <= cfg_data_i[15:0];
        REG_USER_MEA_H: mea_h_q    <= cfg_data_i[15:0];
        REG_TEMP_OFS:   ofs_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  htc_coef #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .recalc_i   (recalc),
    .calib_i    ({calib_hi_q, calib_lo_q}),
    .ref_low_i  (ref_l_q),
    .mea_low_i  (mea_l_q),
    .ref_high_i (ref_h_q),
    .mea_high_i (mea_h_q),
    .coef_o     (coef),
    .busy_o     (coef_busy)
  );

  assign busy = coef_busy;

  always_comb begin
    fac_sum = 34'(coef.t_icpt) + 34'((pt_q + HALF48) >>> COEF_BITS);
    fac_d   = sat32(64'(fac_sum));
    h_sum   = 34'(coef.h_icpt) + 34'((ph_q + HALF48) >>> COEF_BITS);
    if (h_sum < 0) begin
      h2_d = '0;
    end else if (h_sum > 34'sd0 + 34'(HMAX)) begin
      h2_d = 15'(HMAX);
    end else begin
      h2_d = h_sum[14:0];
    end
    t_sum = 50'(coef.u_icpt) + 50'((pu_q + HALF64) >>> COEF_BITS) + 50'(ofs_q);
    if (t_sum > 50'sd32767) begin
      t_d   = 16'sh7FFF;
      sat_d = 1'b1;
    end else if (t_sum < -50'sd32768) begin
      t_d   = 16'sh8000;
      sat_d = 1'b1;
    end else begin
      t_d   = t_sum[15:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q  <= 48'(coef.t_slope) * 48'(temperature_sample_i);
    ph_q  <= 48'(coef.h_slope) * 48'(humidity_sample_i);
    fac_q <= fac_d;
    h2_q  <= h2_d;
    pu_q  <= 64'(coef.u_slope) * 64'(fac_q);
    h3_q  <= h2_q;
    temperature_value_o     <= t_d;
    temperature_saturated_o <= sat_d;
    humidity_value_o        <= h3_q;
  end

  assign result_valid_o = vld_q[3];

endmodule
